// ===== hw/rtl/aomt_pkg.sv =====
// ----------------------------------------------------------------------------
// Address override match table package
// Shared widths, result codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package aomt_pkg;

	localparam int ADDR_W           = 32;
	localparam int HID_W            = 16;
	localparam int S_TDATA_W        = 48;
	localparam int M_TDATA_W        = 88;
	localparam int DEF_TABLE_DEPTH  = 64;
	localparam int DEF_HANDLER_BITS = 16;

	localparam logic CMD_INSTALL = 1'b0;
	localparam logic CMD_LOOKUP  = 1'b1;

	typedef enum logic [1:0] {
		STS_INSTALLED = 2'd0,
		STS_ABSENT    = 2'd1,
		STS_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic scan_start;
		logic scan;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_lookup;
		logic in_range;
		logic hit;
		logic scan_done;
		logic out_free;
	} ctl_sts_t;

endpackage

// ===== hw/rtl/aomt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module aomt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/aomt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Address override match table controller
// Sequences accept, execute, table scan and result hand-off.
// ----------------------------------------------------------------------------
module aomt_ctrl
	import aomt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXEC   = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.is_lookup && sts.in_range) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit || sts.scan_done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/aomt_dp.sv =====
// ----------------------------------------------------------------------------
// Address override match table datapath
// Item registers, table memory, bounds, scan counter and output register.
// ----------------------------------------------------------------------------
module aomt_dp
	import aomt_pkg::*;
#(
	parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
	parameter int HANDLER_BITS = DEF_HANDLER_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [0:0]           s_tuser,
	input  logic                 m_tready,
	output logic                 m_tvalid,
	output logic [M_TDATA_W-1:0] m_tdata,
	input  ctl_cmd_t             cmd,
	output ctl_sts_t             sts
);

	localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int WORD_W = ADDR_W + HANDLER_BITS;

	logic                    lookup_q;
	logic [ADDR_W-1:0]       addr_q;
	logic [HID_W-1:0]        hid_q;
	logic [CNT_W-1:0]        count_q;
	logic [ADDR_W-1:0]       low_q;
	logic [ADDR_W-1:0]       high_q;
	logic [CNT_W-1:0]        rd_idx_q;
	logic                    rd_vld_q;
	status_t                 status_q;
	logic                    found_q;
	logic [HANDLER_BITS-1:0] hout_q;
	logic                    m_tvalid_q;
	logic [M_TDATA_W-1:0]    m_tdata_q;

	logic [HANDLER_BITS-1:0] hid_ext;
	logic [HID_W-1:0]        hout_field;
	logic [WORD_W-1:0]       rd_word;
	logic                    match;
	logic                    rd_issue;
	logic                    addr_zero;
	logic                    full;
	logic                    do_write;

	generate
		if (HANDLER_BITS == HID_W) begin : g_hid_eq
			assign hid_ext    = hid_q;
			assign hout_field = hout_q;
		end else if (HANDLER_BITS > HID_W) begin : g_hid_wide
			assign hid_ext    = {{(HANDLER_BITS - HID_W){1'b0}}, hid_q};
			assign hout_field = hout_q[HID_W-1:0];
		end else begin : g_hid_narrow
			assign hid_ext    = hid_q[HANDLER_BITS-1:0];
			assign hout_field = {{(HID_W - HANDLER_BITS){1'b0}}, hout_q};
		end
	endgenerate

	assign addr_zero = (addr_q == '0);
	assign full      = (count_q >= CNT_W'(TABLE_DEPTH));
	assign do_write  = cmd.exec && !lookup_q && !addr_zero && !full;
	assign match     = rd_vld_q && (rd_word[ADDR_W-1:0] == addr_q);
	assign rd_issue  = cmd.scan && !match && (rd_idx_q < count_q);

	aomt_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TABLE_DEPTH),
		.AW    (IDX_W)
	) u_table (
		.clk     (clk),
		.wr_en   (do_write),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data ({hid_ext, addr_q}),
		.rd_en   (rd_issue),
		.rd_addr (rd_idx_q[IDX_W-1:0]),
		.rd_data (rd_word)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lookup_q <= s_tuser[0];
			addr_q   <= s_tdata[ADDR_W-1:0];
			hid_q    <= s_tdata[ADDR_W+HID_W-1:ADDR_W];
		end
		if (cmd.exec) begin
			found_q <= 1'b0;
			hout_q  <= '0;
			if (lookup_q) begin
				status_q <= STS_INSTALLED;
			end else if (addr_zero) begin
				status_q <= STS_ABSENT;
			end else if (full) begin
				status_q <= STS_FULL;
			end else begin
				status_q <= STS_INSTALLED;
			end
		end
		if (cmd.scan && match) begin
			found_q <= 1'b1;
			hout_q  <= rd_word[WORD_W-1:ADDR_W];
		end
		if (cmd.emit) begin
			m_tdata_q <= {5'd0, high_q, low_q, hout_field, found_q, status_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			low_q      <= '1;
			high_q     <= '0;
			rd_idx_q   <= '0;
			rd_vld_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (do_write) begin
				count_q <= count_q + CNT_W'(1);
				if (addr_q < low_q) begin
					low_q <= addr_q;
				end
				if (addr_q > high_q) begin
					high_q <= addr_q;
				end
			end
			if (cmd.scan_start) begin
				rd_idx_q <= '0;
				rd_vld_q <= 1'b0;
			end else if (rd_issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
				rd_vld_q <= 1'b1;
			end else begin
				rd_vld_q <= 1'b0;
			end
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign sts.is_lookup = lookup_q;
	assign sts.in_range  = (addr_q >= low_q) && (addr_q <= high_q);
	assign sts.hit       = match;
	assign sts.scan_done = (rd_idx_q == count_q) && !match;
	assign sts.out_free  = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== hw/rtl/address_override_match_table_top.sv =====
// ----------------------------------------------------------------------------
// Address override match table
// Installs address-to-handler entries and looks addresses up against them.
// ----------------------------------------------------------------------------
// An install transfer (tuser 0) appends an entry unless its address is zero
// or the table is full, and widens the stored low and high bounds. A lookup
// transfer (tuser 1) is rejected at once when its address lies outside the
// bounds; otherwise the table memory, which has a single read port, is
// scanned one entry per cycle in install order and the first match wins.
// Every result carries the bounds as they stand after the item. One item is
// in work at a time; the result waits in an output register while the next
// item is taken.
// ----------------------------------------------------------------------------
module address_override_match_table_top
	import aomt_pkg::*;
#(
	parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
	parameter int HANDLER_BITS = DEF_HANDLER_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// Fields from bit 0: address[31:0], handler_id[47:32].
	input  logic [S_TDATA_W-1:0] s_tdata,
	// Fields from bit 0: cmd[0].
	input  logic [0:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// Fields from bit 0: status[1:0], found[2], handler_out[18:3],
	// range_low[50:19], range_high[82:51], zero fill[87:83].
	output logic [M_TDATA_W-1:0] m_tdata
);

	ctl_cmd_t ctl_cmd;
	ctl_sts_t ctl_sts;

	aomt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (ctl_sts),
		.cmd      (ctl_cmd)
	);

	aomt_dp #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.HANDLER_BITS (HANDLER_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.cmd      (ctl_cmd),
		.sts      (ctl_sts)
	);

endmodule

// ===== sim/address_override_match_table_checker.sv =====
// ----------------------------------------------------------------------------
// Address override match table checker
// Watches both stream channels, keeps its own copy of the table and bounds,
// predicts the reply to every accepted item and compares each reply field.
// ----------------------------------------------------------------------------
module address_override_match_table_checker
	import aomt_pkg::*;
#(
	parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
	parameter int HANDLER_BITS = DEF_HANDLER_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	// Fields from bit 0: address[31:0], handler_id[47:32].
	input  logic [S_TDATA_W-1:0] s_tdata,
	// Fields from bit 0: cmd[0].
	input  logic [0:0]           s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	// Fields from bit 0: status[1:0], found[2], handler_out[18:3],
	// range_low[50:19], range_high[82:51], zero fill[87:83].
	input  logic [M_TDATA_W-1:0] m_tdata,
	output int                   fail_count,
	output int                   pending,
	output int                   checked_count,
	output int                   hit_count,
	output int                   reject_count,
	output int                   full_count
);

	localparam logic [31:0] HANDLER_MASK = (HANDLER_BITS >= 32) ? 32'hFFFF_FFFF :
		((32'd1 << HANDLER_BITS) - 32'd1);
	localparam int MAX_REPORTS = 60;

	typedef struct packed {
		status_t            status;
		logic               found;
		logic [HID_W-1:0]   handler;
		logic [ADDR_W-1:0]  range_low;
		logic [ADDR_W-1:0]  range_high;
	} table_reply_t;

	logic [ADDR_W-1:0] shadow_addr [TABLE_DEPTH];
	logic [31:0]       shadow_handler [TABLE_DEPTH];
	int                shadow_count;
	logic [ADDR_W-1:0] shadow_low;
	logic [ADDR_W-1:0] shadow_high;

	table_reply_t      awaited_replies [$];
	table_reply_t      want;
	logic [M_TDATA_W-1:0] got;

	function automatic table_reply_t compute_table_reply(input logic cmd,
			input logic [ADDR_W-1:0] addr, input logic [HID_W-1:0] hid);
		table_reply_t r;
		logic done;
		r.status = STS_INSTALLED;
		r.found = 1'b0;
		r.handler = '0;
		if (cmd == CMD_INSTALL) begin
			if (addr == '0) begin
				r.status = STS_ABSENT;
			end else if (shadow_count >= TABLE_DEPTH) begin
				r.status = STS_FULL;
				full_count++;
			end else begin
				shadow_addr[shadow_count] = addr;
				shadow_handler[shadow_count] = {16'd0, hid} & HANDLER_MASK;
				shadow_count++;
				if (addr < shadow_low)
					shadow_low = addr;
				if (addr > shadow_high)
					shadow_high = addr;
			end
		end else if (addr >= shadow_low && addr <= shadow_high) begin
			done = 1'b0;
			for (int i = 0; i < shadow_count; i++) begin
				if (!done && shadow_addr[i] == addr) begin
					r.found = 1'b1;
					r.handler = shadow_handler[i][HID_W-1:0];
					done = 1'b1;
				end
			end
			if (done)
				hit_count++;
		end else begin
			reject_count++;
		end
		r.range_low = shadow_low;
		r.range_high = shadow_high;
		return r;
	endfunction

	task automatic check_field(input string what, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			if (fail_count < MAX_REPORTS)
				$display("%0t: reply %0d %s expected %h actual %h", $time, checked_count,
					what, exp_val, act_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_count = 0;
			shadow_low = '1;
			shadow_high = '0;
			awaited_replies.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (awaited_replies.size() == 0) begin
					if (fail_count < MAX_REPORTS)
						$display("%0t: reply %0d expected none actual %h", $time,
							checked_count, got);
					fail_count++;
				end else begin
					want = awaited_replies.pop_front();
					check_field("status", 32'(want.status), 32'(got[1:0]));
					check_field("found", 32'(want.found), 32'(got[2]));
					check_field("handler_out", 32'(want.handler), 32'(got[18:3]));
					check_field("range_low", want.range_low, got[50:19]);
					check_field("range_high", want.range_high, got[82:51]);
					check_field("zero fill", 32'd0, 32'(got[87:83]));
				end
				checked_count++;
			end
			if (s_tvalid && s_tready)
				awaited_replies.push_back(compute_table_reply(s_tuser[0], s_tdata[31:0],
					s_tdata[47:32]));
			pending = awaited_replies.size();
		end
	end

endmodule

// ===== sim/tb_address_override_match_table_top.sv =====
// ----------------------------------------------------------------------------
// Address override match table testbench
// Drives install and lookup transfers in random bursts against a receiver
// that stalls on its own pattern, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_address_override_match_table_top;
	import aomt_pkg::*;

	localparam int RANDOM_ITEMS = 800;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RX_STEADY = 0;
	localparam int RX_COIN   = 1;
	localparam int RX_MOSTLY = 2;
	localparam int RX_SPARSE = 3;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [0:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	int fail_count;
	int pending;
	int checked_count;
	int hit_count;
	int reject_count;
	int full_count;

	int cycle_count;
	int burst_left;
	bit gaps_on;
	int hold_asked;
	int hold_served;
	int hold_left;
	int rx_mode;
	int rx_mode_left;
	logic [ADDR_W-1:0] known_addrs [$];

	address_override_match_table_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	address_override_match_table_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked_count (checked_count),
		.hit_count     (hit_count),
		.reject_count  (reject_count),
		.full_count    (full_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			hold_served <= 0;
			rx_mode <= RX_STEADY;
			rx_mode_left <= 0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_asked) begin
			hold_served <= hold_asked;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode <= $urandom_range(RX_SPARSE, RX_STEADY);
				rx_mode_left <= $urandom_range(200, 20);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			case (rx_mode)
				RX_STEADY: m_tready <= 1'b1;
				RX_COIN:   m_tready <= ($urandom_range(1, 0) != 0);
				RX_MOSTLY: m_tready <= ($urandom_range(7, 0) != 0);
				default:   m_tready <= ($urandom_range(3, 0) == 0);
			endcase
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: run exceeded %0d cycles with %0d replies outstanding", $time,
			CYCLE_LIMIT, pending);
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_item(input logic cmd, input logic [ADDR_W-1:0] addr,
			input logic [HID_W-1:0] hid);
		logic [63:0] noise;
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {hid, addr};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (cmd == CMD_INSTALL && addr != '0 && known_addrs.size() < DEF_TABLE_DEPTH)
			known_addrs.push_back(addr);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(12, 0);
			if (gaps_on) begin
				noise = {$urandom, $urandom};
				s_tvalid <= 1'b0;
				s_tdata <= noise[S_TDATA_W-1:0];
				s_tuser <= noise[63];
				if ($urandom_range(7, 0) == 0)
					repeat ($urandom_range(30, 10)) @(posedge clk);
				else
					repeat ($urandom_range(4, 1)) @(posedge clk);
			end
		end
	endtask

	function automatic logic [ADDR_W-1:0] pick_known();
		if (known_addrs.size() == 0)
			return $urandom;
		return known_addrs[$urandom_range(known_addrs.size() - 1, 0)];
	endfunction

	initial begin
		int pick;
		logic [ADDR_W-1:0] addr;
		logic [HID_W-1:0] hid;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_INSTALL;
		burst_left = 0;
		gaps_on = 1'b1;
		hold_asked = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// An empty table rejects every lookup, the extremes included.
		send_item(CMD_LOOKUP, 32'h0000_0000, 16'h0000);
		send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(CMD_LOOKUP, 32'h1234_5678, 16'h1234);
		send_item(CMD_INSTALL, 32'h0000_0000, 16'hFFFF);
		send_item(CMD_INSTALL, 32'h8000_0000, 16'h0000);
		send_item(CMD_LOOKUP, 32'h7FFF_FFFF, 16'h0000);
		send_item(CMD_LOOKUP, 32'h8000_0001, 16'h0000);
		send_item(CMD_LOOKUP, 32'h8000_0000, 16'hFFFF);
		// A duplicate install must not shadow the first entry.
		send_item(CMD_INSTALL, 32'h8000_0000, 16'hFFFF);
		send_item(CMD_LOOKUP, 32'h8000_0000, 16'h0000);
		send_item(CMD_INSTALL, 32'h4000_0000, 16'h5A5A);
		send_item(CMD_INSTALL, 32'hC000_0000, 16'hA5A5);
		send_item(CMD_LOOKUP, 32'h6000_0000, 16'h0000);
		send_item(CMD_LOOKUP, 32'hC000_0000, 16'h0000);
		send_item(CMD_LOOKUP, 32'hC000_0001, 16'h0000);
		send_item(CMD_LOOKUP, 32'h3FFF_FFFF, 16'h0000);
		send_item(CMD_INSTALL, 32'h0000_0000, 16'h1357);
		send_item(CMD_LOOKUP, 32'h4000_0000, 16'hFFFF);
		send_item(CMD_INSTALL, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 16'h0000);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			gaps_on = !(i >= 300 && i < 400);
			if (i == 500)
				hold_asked++;
			hid = HID_W'($urandom);
			pick = $urandom_range(99, 0);
			if ($urandom_range(99, 0) < 40) begin
				if (pick < 5)
					addr = '0;
				else if (pick < 8)
					addr = 32'h0000_0001;
				else if (pick < 20)
					addr = pick_known();
				else if (pick < 80)
					addr = $urandom_range(32'hBFFF_FFFF, 32'h4000_0000);
				else
					addr = $urandom;
				send_item(CMD_INSTALL, addr, hid);
			end else begin
				if (pick < 50)
					addr = pick_known();
				else if (pick < 62)
					addr = pick_known() + (pick[0] ? 32'd1 : -32'd1);
				else if (pick < 72)
					addr = '0;
				else if (pick < 78)
					addr = 32'hFFFF_FFFF;
				else
					addr = $urandom;
				send_item(CMD_LOOKUP, addr, hid);
			end
		end
		s_tvalid <= 1'b0;

		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Checked %0d replies over %0d installs into a table of %0d entries.",
			checked_count, known_addrs.size(), DEF_TABLE_DEPTH);
		$display("Lookups: %0d hits, %0d rejected by the bounds; %0d installs hit a full table.",
			hit_count, reject_count, full_count);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
